>>> rtl/mlvb_pkg.sv
// Shared types and codes for the multi-list vector buffer.
package mlvb_pkg;

  localparam int CFG_W       = 5;
  localparam int FUNC_W      = 2;
  localparam int INDEX_W     = 4;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int MAX_LISTS   = 16;

  localparam logic [CFG_W-1:0] LISTS_RESET = 5'd16;

  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DUMP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [INDEX_W-1:0]       list_index;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic                     is_element;
    logic                     last;
    logic [STATUS_W-1:0]      status;
  } rsp_t;

endpackage

>>> rtl/mlvb_store.sv
// Element store: one write port, one read port, registered read data.
module mlvb_store #(
  parameter int ADDR_W = 10,
  parameter int WIDTH  = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/multi_list_vector_buffer.sv
// Multi-list vector buffer top level: count memory, control sequencer, output register.
// Push, clear, unused func and rejected index: request taken, then lookup registers the result;
//   input is stalled until that result is registered, set by the count memory read-modify-write.
// Dump of n elements: n results at one per cycle while out_stall is low, after the lookup,
//   limited by the single element store read port; input is stalled for the whole dump.
// Reset clears the per-list valid bits at once (every count reads as zero, no sweep),
//   sets lists_in_use to 16 and empties the output register.
module multi_list_vector_buffer #(
  parameter int NUM_LISTS     = 16,
  parameter int LIST_CAPACITY = 64,
  parameter int VALUE_WIDTH   = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mlvb_pkg::req_t                  in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output mlvb_pkg::rsp_t                  out_data,
  // configuration write (lists_in_use)
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mlvb_pkg::CFG_W-1:0]      cfg_data
);

  // Only the first MAX_LISTS lists can ever be addressed by a 4-bit index.
  localparam int CNT_DEPTH = (NUM_LISTS < mlvb_pkg::MAX_LISTS) ? NUM_LISTS
                                                               : mlvb_pkg::MAX_LISTS;
  localparam int CIDX_W    = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;
  localparam int OFF_W     = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int CNT_W     = $clog2(LIST_CAPACITY + 1);
  localparam int ADDR_W    = CIDX_W + OFF_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_DUMP
  } state_t;

  state_t                      state;
  mlvb_pkg::req_t              req_q;
  logic                        err_q;
  logic [mlvb_pkg::CFG_W-1:0]  lists_in_use;

  // count memory plus a valid bit per list so reset needs no clearing pass
  logic [CNT_W-1:0]            cnt_mem [CNT_DEPTH];
  logic [CNT_DEPTH-1:0]        cnt_valid;
  logic [CNT_W-1:0]            cnt_rdata;
  logic                        cnt_rvld;
  logic                        cnt_re;
  logic [CIDX_W-1:0]           cnt_raddr;
  logic                        cnt_we;
  logic [CNT_W-1:0]            cnt_wdata;
  logic [CNT_W-1:0]            cnt_val;
  logic                        cnt_full;

  // element store handshake
  logic                        st_we;
  logic                        st_re;
  logic [OFF_W-1:0]            st_roff;
  logic [ADDR_W-1:0]           st_raddr;
  logic [ADDR_W-1:0]           st_waddr;
  logic [VALUE_WIDTH-1:0]      st_wdata;
  logic [VALUE_WIDTH-1:0]      st_rdata;

  // dump progress: ptr counts reads issued, dump_len is the list length
  logic [CNT_W-1:0]            ptr;
  logic [CNT_W-1:0]            dump_len;

  logic                        out_free;
  logic                        accept;
  logic                        range_err;
  logic [CIDX_W-1:0]           list_sel;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  // output register can take a new result this cycle
  assign out_free  = !out_valid || !out_stall;

  // reject at or above the configured list count or beyond the built lists
  assign range_err = ({1'b0, in_data.list_index} >= lists_in_use) ||
                     (32'(in_data.list_index) >= NUM_LISTS);

  assign list_sel  = req_q.list_index[CIDX_W-1:0];
  assign cnt_raddr = in_data.list_index[CIDX_W-1:0];
  assign cnt_re    = accept;
  assign cnt_val   = cnt_rvld ? cnt_rdata : '0;
  assign cnt_full  = (cnt_val >= CNT_W'(LIST_CAPACITY));

  // pushed value is sign extended (or truncated) to the stored width
  assign st_wdata  = VALUE_WIDTH'(req_q.value);
  assign st_waddr  = {list_sel, cnt_val[OFF_W-1:0]};
  assign st_raddr  = {list_sel, st_roff};

  // memory-side control for the lookup and dump steps
  always_comb begin
    cnt_we    = 1'b0;
    cnt_wdata = '0;
    st_we     = 1'b0;
    st_re     = 1'b0;
    st_roff   = '0;
    if (state == S_LOOKUP && out_free && !err_q) begin
      case (req_q.func)
        mlvb_pkg::FUNC_PUSH: begin
          if (!cnt_full) begin
            st_we     = 1'b1;
            cnt_we    = 1'b1;
            cnt_wdata = cnt_val + CNT_W'(1);
          end
        end
        mlvb_pkg::FUNC_DUMP: begin
          st_re = (cnt_val != '0);
        end
        mlvb_pkg::FUNC_CLEAR: begin
          cnt_we = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (state == S_DUMP && out_free && (ptr != dump_len)) begin
      st_re   = 1'b1;
      st_roff = ptr[OFF_W-1:0];
    end
  end

  // count memory: registered read, no reset on the array itself
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[list_sel] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata <= cnt_mem[cnt_raddr];
    end
  end

  mlvb_store #(
    .ADDR_W (ADDR_W),
    .WIDTH  (VALUE_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // sequencer, valid bits, config register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      cnt_valid    <= '0;
      cnt_rvld     <= 1'b0;
      lists_in_use <= mlvb_pkg::LISTS_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lists_in_use <= cfg_data;
      end
      if (cnt_re) begin
        cnt_rvld <= cnt_valid[cnt_raddr];
      end
      if (cnt_we) begin
        cnt_valid[list_sel] <= 1'b1;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            req_q <= in_data;
            err_q <= range_err;
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (out_free) begin
            // default single-result answer
            out_data.element    <= '0;
            out_data.is_element <= 1'b0;
            out_data.last       <= 1'b1;
            out_data.status     <= mlvb_pkg::STATUS_OK;
            out_valid           <= 1'b1;
            state               <= S_IDLE;
            if (err_q) begin
              out_data.status <= mlvb_pkg::STATUS_RANGE;
            end else if (req_q.func == mlvb_pkg::FUNC_PUSH) begin
              if (cnt_full) begin
                out_data.status <= mlvb_pkg::STATUS_FULL;
              end
            end else if (req_q.func == mlvb_pkg::FUNC_DUMP && cnt_val != '0) begin
              // first read issued now; results come from the dump state
              out_valid <= 1'b0;
              ptr       <= CNT_W'(1);
              dump_len  <= cnt_val;
              state     <= S_DUMP;
            end
          end
        end
        S_DUMP: begin
          if (out_free) begin
            out_data.element    <= $signed(32'(st_rdata));
            out_data.is_element <= 1'b1;
            out_data.last       <= (ptr == dump_len);
            out_data.status     <= mlvb_pkg::STATUS_OK;
            out_valid           <= 1'b1;
            if (ptr == dump_len) begin
              state <= S_IDLE;
            end else begin
              ptr <= ptr + CNT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a dumped element always reports ok
  a_elem_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.is_element) |-> (out_data.status == mlvb_pkg::STATUS_OK))
    else $error("dumped element with bad status");

  // an error result is always a lone, final, element-free result
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != mlvb_pkg::STATUS_OK) |->
      (out_data.last && !out_data.is_element))
    else $error("error result not single");

  // stored counts never exceed capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOKUP) |-> (cnt_val <= CNT_W'(LIST_CAPACITY)))
    else $error("list count beyond capacity");

  // dump pointer stays within the list length
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |-> (ptr != '0 && ptr <= dump_len))
    else $error("dump pointer out of range");

  // a non-empty dump start produces no result in the same cycle
  a_dump_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOKUP && out_free && !err_q && req_q.func == mlvb_pkg::FUNC_DUMP &&
     cnt_val != '0) |=> (state == S_DUMP && !out_valid))
    else $error("dump start emitted a result");

endmodule

>>> bench/tb_multi_list_vector_buffer.sv
// Self-checking testbench for the multi-list vector buffer: scoreboard, stimulus, stall patterns.
`timescale 1ns / 1ps

module tb_multi_list_vector_buffer;

  // Block sizes; the instance below uses the same values.
  localparam int NLISTS      = 16;
  localparam int CAPACITY    = 64;
  localparam int STORE_DEPTH = NLISTS * CAPACITY;

  // The package names three funcs only; the fourth code is a no-op.
  localparam logic [mlvb_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

  localparam int LIMIT_CYCLES = 1000000;  // watchdog, far above the slowest legal run
  localparam int HOLD_CYCLES  = 250;      // long receiver hold-off to back the block up

  // ---------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the list counts, the element store and
  // the lists_in_use register, expands each accepted request into the results
  // it must cause, and matches them in order against what the block returns.
  // ---------------------------------------------------------------------------
  class list_buffer_scoreboard;
    logic [mlvb_pkg::CFG_W-1:0]  lists_limit;
    logic [6:0]                  counts [NLISTS];
    logic [mlvb_pkg::DATA_W-1:0] elems [STORE_DEPTH];
    mlvb_pkg::rsp_t              awaited_results [$];
    int                          errors;

    function new();
      lists_limit = mlvb_pkg::LISTS_RESET;
      foreach (counts[i]) counts[i] = '0;
      errors = 0;
    endfunction

    function void set_lists(logic [mlvb_pkg::CFG_W-1:0] v);
      lists_limit = v;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void add(logic signed [mlvb_pkg::DATA_W-1:0] el, logic is_el, logic lst,
                      logic [mlvb_pkg::STATUS_W-1:0] st);
      mlvb_pkg::rsp_t r;
      r.element    = el;
      r.is_element = is_el;
      r.last       = lst;
      r.status     = st;
      awaited_results.push_back(r);
    endfunction

    function void note_request(mlvb_pkg::req_t r);
      int unsigned idx;
      int unsigned base;
      int unsigned n;
      idx  = 32'(r.list_index);
      base = idx * CAPACITY;
      // rejected index: nothing changes, whatever the func
      if (idx >= 32'(lists_limit) || idx >= NLISTS) begin
        add('0, 1'b0, 1'b1, mlvb_pkg::STATUS_RANGE);
        return;
      end
      n = 32'(counts[idx]);
      case (r.func)
        mlvb_pkg::FUNC_PUSH: begin
          if (n >= CAPACITY) begin
            add('0, 1'b0, 1'b1, mlvb_pkg::STATUS_FULL);
          end else begin
            elems[base + n] = r.value;
            counts[idx]     = 7'(n + 1);
            add('0, 1'b0, 1'b1, mlvb_pkg::STATUS_OK);
          end
        end
        mlvb_pkg::FUNC_DUMP: begin
          if (n == 0) begin
            add('0, 1'b0, 1'b1, mlvb_pkg::STATUS_OK);
          end else begin
            for (int i = 0; i < n; i++)
              add(elems[base + i], 1'b1, (i == n - 1), mlvb_pkg::STATUS_OK);
          end
        end
        mlvb_pkg::FUNC_CLEAR: begin
          counts[idx] = '0;
          add('0, 1'b0, 1'b1, mlvb_pkg::STATUS_OK);
        end
        default: begin
          add('0, 1'b0, 1'b1, mlvb_pkg::STATUS_OK);
        end
      endcase
    endfunction

    function void check_result(mlvb_pkg::rsp_t got);
      mlvb_pkg::rsp_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %0d/%0b/%0b/%0d",
                 $time, got.element, got.is_element, got.last, got.status);
        return;
      end
      want = awaited_results.pop_front();
      if (got.element !== want.element) begin
        errors++;
        $display("%0t: element expected %0d actual %0d", $time, want.element, got.element);
      end
      if (got.is_element !== want.is_element) begin
        errors++;
        $display("%0t: is_element expected %0b actual %0b", $time, want.is_element,
                 got.is_element);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  mlvb_pkg::req_t             in_data   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  mlvb_pkg::rsp_t             out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [mlvb_pkg::CFG_W-1:0] cfg_data  = '0;

  always #10 clk = ~clk;

  multi_list_vector_buffer #(
    .NUM_LISTS    (NLISTS),
    .LIST_CAPACITY(CAPACITY),
    .VALUE_WIDTH  (mlvb_pkg::DATA_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  list_buffer_scoreboard sb;

  // Testbench-side copy of lists_in_use, used only to aim stimulus at live lists.
  int cur_lists = int'(mlvb_pkg::LISTS_RESET);
  // Sender burst bookkeeping.
  int burst_left = 0;
  // Hold-off handshake: the stimulus bumps hold_requests, the receiver
  // answers by bumping holds_done and stalling for HOLD_CYCLES.
  int hold_requests = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int rx_mode       = 0;
  int mode_left     = 0;
  int cycles        = 0;

  // ---------------------------------------------------------------------------
  // Watchdog: a hung handshake or a missing result ends the run here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: check every accepted result, then pick the next stall value.
  // Stall runs in modes of random length (none, light, heavy) so gaps land on
  // every phase of a dump; a hold request overrides with a long solid stall.
  // out_stall read here is the value seen by the block at this edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result(out_data);
      if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side tasks. All are entered and left at a rising edge.
  // ---------------------------------------------------------------------------
  function automatic mlvb_pkg::req_t make_req(logic [mlvb_pkg::FUNC_W-1:0] f,
                                              logic [mlvb_pkg::INDEX_W-1:0] idx,
                                              logic [mlvb_pkg::DATA_W-1:0] v);
    mlvb_pkg::req_t r;
    r.func       = f;
    r.list_index = idx;
    r.value      = v;
    return r;
  endfunction

  // Offer one request and wait for it to be taken. Requests go out in
  // bursts; between bursts valid drops for a random gap (sometimes none).
  task automatic offer(input mlvb_pkg::req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  // Stop offering and wait for every expected result, plus a few cycles
  // for anything stray to show up.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write lists_in_use; only called with the block idle.
  task automatic write_lists(input logic [mlvb_pkg::CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_lists(v);
    cur_lists = int'(v);
  endtask

  // Mostly well-formed traffic on live lists: a few pushes then a dump,
  // sometimes a clear. The rest is noise (any func incl. the spare code,
  // any index) and bare dumps.
  task automatic run_traffic(input int n);
    int sent;
    int kind;
    int lst;
    int k;
    int live;
    sent = 0;
    while (sent < n) begin
      live = (cur_lists > NLISTS) ? NLISTS : cur_lists;
      lst  = (live == 0) ? $urandom_range(0, NLISTS - 1) : $urandom_range(0, live - 1);
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++)
          offer(make_req(mlvb_pkg::FUNC_PUSH, mlvb_pkg::INDEX_W'(lst), $urandom));
        offer(make_req(mlvb_pkg::FUNC_DUMP, mlvb_pkg::INDEX_W'(lst), $urandom));
        sent += k + 1;
        if ($urandom_range(0, 3) == 0) begin
          offer(make_req(mlvb_pkg::FUNC_CLEAR, mlvb_pkg::INDEX_W'(lst), $urandom));
          sent++;
        end
      end else if (kind < 85) begin
        offer(make_req(mlvb_pkg::FUNC_W'($urandom_range(0, 3)),
                       mlvb_pkg::INDEX_W'($urandom_range(0, NLISTS - 1)), $urandom));
        sent++;
      end else begin
        offer(make_req(mlvb_pkg::FUNC_DUMP, mlvb_pkg::INDEX_W'(lst), $urandom));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  logic [mlvb_pkg::CFG_W-1:0] cfg_plan [6];
  int                         fill_list;

  initial begin
    sb = new();
    // 31 and 0 are the register extremes (above 16 acts as 16, 0 rejects all);
    // 1 leaves a single list live.
    cfg_plan = '{5'd31, 5'd1, 5'd0, 5'd7, 5'd0, mlvb_pkg::LISTS_RESET};
    cfg_plan[4] = mlvb_pkg::CFG_W'($urandom_range(2, 15));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty dump, value extremes, both end lists, spare func,
    // value ignored on dump/clear, clear of non-empty and empty lists.
    offer(make_req(mlvb_pkg::FUNC_DUMP,  4'd0,  32'h0000_0000));
    offer(make_req(mlvb_pkg::FUNC_PUSH,  4'd0,  32'h7FFF_FFFF));
    offer(make_req(mlvb_pkg::FUNC_PUSH,  4'd0,  32'h8000_0000));
    offer(make_req(mlvb_pkg::FUNC_PUSH,  4'd0,  32'h0000_0000));
    offer(make_req(mlvb_pkg::FUNC_PUSH,  4'd0,  32'hFFFF_FFFF));
    offer(make_req(mlvb_pkg::FUNC_DUMP,  4'd0,  32'hFFFF_FFFF));
    offer(make_req(mlvb_pkg::FUNC_PUSH,  4'd15, 32'hA5A5_A5A5));
    offer(make_req(mlvb_pkg::FUNC_PUSH,  4'd15, 32'h5A5A_5A5A));
    offer(make_req(mlvb_pkg::FUNC_DUMP,  4'd15, 32'h1234_5678));
    offer(make_req(FUNC_SPARE,           4'd3,  $urandom));
    offer(make_req(mlvb_pkg::FUNC_DUMP,  4'd9,  32'hDEAD_BEEF));
    offer(make_req(mlvb_pkg::FUNC_CLEAR, 4'd0,  32'hFFFF_FFFF));
    offer(make_req(mlvb_pkg::FUNC_DUMP,  4'd0,  32'h0000_0000));
    offer(make_req(mlvb_pkg::FUNC_CLEAR, 4'd15, 32'h0000_0000));
    offer(make_req(mlvb_pkg::FUNC_CLEAR, 4'd7,  32'h0000_0000));
    offer(make_req(mlvb_pkg::FUNC_DUMP,  4'd15, 32'h0000_0000));

    // Fill one list past capacity: the last two pushes must come back full,
    // then a full-length dump.
    fill_list = $urandom_range(0, NLISTS - 1);
    offer(make_req(mlvb_pkg::FUNC_CLEAR, mlvb_pkg::INDEX_W'(fill_list), $urandom));
    for (int i = 0; i < CAPACITY + 2; i++)
      offer(make_req(mlvb_pkg::FUNC_PUSH, mlvb_pkg::INDEX_W'(fill_list), $urandom));
    offer(make_req(mlvb_pkg::FUNC_DUMP, mlvb_pkg::INDEX_W'(fill_list), $urandom));

    // Back-pressure: long receiver hold while requests keep coming.
    hold_requests++;
    run_traffic(45);
    settle();

    // Register phases, each started with the block idle.
    foreach (cfg_plan[p]) begin
      write_lists(cfg_plan[p]);
      if (cfg_plan[p] == 5'd7)
        hold_requests++;
      run_traffic(45);
      settle();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
